// ===== design/tsd_pkg.sv =====
// Shared widths, status codes and stage structures for the triangle slope unit.
// No dependencies; every other design file imports this package.
package tsd_pkg;

  localparam int COORD_W    = 20;
  localparam int NUM_COORD  = 9;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int NRM_W      = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int HALF_W     = MAG_W / 2;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int H2_W       = SQ_W + 1;
  localparam int RAD_W      = 116;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQ_STEPS   = ROOT_W;
  localparam int GRADE_W    = 24;
  localparam int DIR_FRAC   = 14;
  localparam int DIR_W      = 16;
  localparam int DVS_W      = H2_W + 1;
  localparam int DREM_W     = DVS_W + 1;
  localparam int FEED_W     = 2 * DIR_FRAC + 1;
  localparam int DSQ_STEPS  = DIR_FRAC + 1;
  localparam int IN_W       = 184;
  localparam int OUT_W      = 56;
  localparam int USER_W     = 3;
  localparam int CFG_W      = 24;

  localparam logic [GRADE_W-1:0] GRADE_MAX = {GRADE_W{1'b1}};

  localparam logic [1:0] ST_PLANAR = 2'd0;
  localparam logic [1:0] ST_DEGEN  = 2'd1;
  localparam logic [1:0] ST_VERT   = 2'd2;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sqrt_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [DVS_W-1:0]  dvs;
    logic [FEED_W-1:0] feed;
    logic [FEED_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] mz;
  } side_t;

  typedef struct packed {
    logic sat;
    logic rnz;
  } gflag_t;

endpackage

// ===== design/triangle_slope_and_downhill_unit.sv =====
// Triangle slope and downhill direction unit, top level.
// Pipeline from an input transfer to its result on the output register:
// 7 front stages, 58 square root cells, one saturation stage, 24 divider cells.
// Throughput is one triangle per cycle; the whole chain holds while a result waits.
// Synchronous active-low reset clears the valid bits, including out_tvalid, and flat_grade (flat_r).
// Depends on tsd_pkg, tsd_front, tsd_sqrt_cell and tsd_div_cell.
module triangle_slope_and_downhill_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz (20 bits each), 4 zero pad bits
  input  logic [tsd_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // grade (24), down_x (16), down_y (16)
  output logic [tsd_pkg::OUT_W-1:0]    out_tdata,
  // plane_status (2), has_direction (1)
  output logic [tsd_pkg::USER_W-1:0]   out_tuser,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tsd_pkg::CFG_W-1:0]    cfg_data
);
  import tsd_pkg::*;

  localparam int S_SIDE = 3;
  localparam int S_H2   = 6;
  localparam int S_RAD  = 7;
  localparam int S_ROOT = S_RAD + SQ_STEPS;
  localparam int S_SAT  = S_ROOT + 1;
  localparam int S_END  = S_SAT + GRADE_W;
  localparam int S_DIR  = S_H2 + FEED_W + DSQ_STEPS;

  logic                  en;
  logic [GRADE_W-1:0]    flat_r;
  logic                  vld_r [1:S_END];
  side_t                 side_r [S_SIDE+1:S_END];
  gflag_t                gf_r [S_SAT:S_END];
  logic [2*DIR_FRAC+1:0] dl_r [S_DIR+1:S_END];
  side_t                 side3;
  logic [SQ_W-1:0]       mx2_6;
  logic [SQ_W-1:0]       my2_6;
  logic [H2_W-1:0]       h2_6;
  logic [RAD_W-1:0]      rad_7;
  sqrt_t                 sq_c [SQ_STEPS+1];
  div_t                  gd_c [GRADE_W+1];
  div_t                  dx_c [FEED_W+1];
  div_t                  dy_c [FEED_W+1];
  sqrt_t                 sx_c [DSQ_STEPS+1];
  sqrt_t                 sy_c [DSQ_STEPS+1];
  div_t                  gd_in_r;
  logic [ROOT_W-1:0]     root_s;
  logic                  sat_nxt;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;
  logic [USER_W-1:0]     out_user_r;
  logic [GRADE_W-1:0]    grade_nxt;
  logic                  hd_nxt;
  logic [GRADE_W-1:0]    quo_g;
  logic                  rem_nz;
  logic [DIR_W-1:0]      ext_x;
  logic [DIR_W-1:0]      ext_y;
  logic [DIR_W-1:0]      dx_nxt;
  logic [DIR_W-1:0]      dy_nxt;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  tsd_front u_front (
    .clk      (clk),
    .en       (en),
    .in_tdata (in_tdata),
    .side3    (side3),
    .mx2_6    (mx2_6),
    .h2_6     (h2_6),
    .my2_6    (my2_6),
    .rad_7    (rad_7)
  );

  assign sq_c[0] = '{rad: rad_7, root: '0, rem: '0};
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    tsd_sqrt_cell u_cell (.clk(clk), .en(en), .d_in(sq_c[i]), .d_out(sq_c[i+1]));
  end

  assign root_s  = sq_c[SQ_STEPS].root;
  assign sat_nxt = (ROOT_W + 8)'(root_s) >= (ROOT_W + 8)'({side_r[S_ROOT].mz, GRADE_W'(0)});

  assign gd_c[0] = gd_in_r;
  for (genvar i = 0; i < GRADE_W; i++) begin : g_gd
    tsd_div_cell u_cell (.clk(clk), .en(en), .d_in(gd_c[i]), .d_out(gd_c[i+1]));
  end

  assign dx_c[0] = '{rem: DREM_W'(mx2_6 >> 1), dvs: DVS_W'(h2_6),
                     feed: {mx2_6[0], (FEED_W-1)'(0)}, quo: '0};
  assign dy_c[0] = '{rem: DREM_W'(my2_6 >> 1), dvs: DVS_W'(h2_6),
                     feed: {my2_6[0], (FEED_W-1)'(0)}, quo: '0};
  for (genvar i = 0; i < FEED_W; i++) begin : g_dd
    tsd_div_cell u_cx (.clk(clk), .en(en), .d_in(dx_c[i]), .d_out(dx_c[i+1]));
    tsd_div_cell u_cy (.clk(clk), .en(en), .d_in(dy_c[i]), .d_out(dy_c[i+1]));
  end

  assign sx_c[0] = '{rad: {1'b0, dx_c[FEED_W].quo, (RAD_W-FEED_W-1)'(0)}, root: '0, rem: '0};
  assign sy_c[0] = '{rad: {1'b0, dy_c[FEED_W].quo, (RAD_W-FEED_W-1)'(0)}, root: '0, rem: '0};
  for (genvar i = 0; i < DSQ_STEPS; i++) begin : g_ds
    tsd_sqrt_cell u_sx (.clk(clk), .en(en), .d_in(sx_c[i]), .d_out(sx_c[i+1]));
    tsd_sqrt_cell u_sy (.clk(clk), .en(en), .d_in(sy_c[i]), .d_out(sy_c[i+1]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[S_SIDE+1] <= side3;
      for (int k = S_SIDE + 2; k <= S_END; k++) begin
        side_r[k] <= side_r[k-1];
      end
      gd_in_r.rem  <= DREM_W'(root_s >> GRADE_W);
      gd_in_r.dvs  <= DVS_W'(side_r[S_ROOT].mz);
      gd_in_r.feed <= {root_s[GRADE_W-1:0], (FEED_W-GRADE_W)'(0)};
      gd_in_r.quo  <= '0;
      gf_r[S_SAT]  <= '{sat: sat_nxt, rnz: sq_c[SQ_STEPS].rem != '0};
      for (int k = S_SAT + 1; k <= S_END; k++) begin
        gf_r[k] <= gf_r[k-1];
      end
      dl_r[S_DIR+1] <= {sy_c[DSQ_STEPS].root[DIR_FRAC:0], sx_c[DSQ_STEPS].root[DIR_FRAC:0]};
      for (int k = S_DIR + 2; k <= S_END; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  always_comb begin
    quo_g  = gd_c[GRADE_W].quo[GRADE_W-1:0];
    rem_nz = gd_c[GRADE_W].rem != '0;
    case (side_r[S_END].status)
      ST_DEGEN: begin
        grade_nxt = '0;
        hd_nxt    = 1'b0;
      end
      ST_VERT: begin
        grade_nxt = GRADE_MAX;
        hd_nxt    = 1'b0;
      end
      default: begin
        if (gf_r[S_END].sat) begin
          grade_nxt = GRADE_MAX;
          hd_nxt    = 1'b1;
        end else begin
          grade_nxt = quo_g;
          hd_nxt    = (quo_g > flat_r)
                      || (quo_g == flat_r && (rem_nz || gf_r[S_END].rnz));
        end
      end
    endcase
    ext_x = {1'b0, dl_r[S_END][DIR_FRAC:0]};
    ext_y = {1'b0, dl_r[S_END][2*DIR_FRAC+1:DIR_FRAC+1]};
    if (!hd_nxt) begin
      dx_nxt = '0;
      dy_nxt = '0;
    end else begin
      dx_nxt = side_r[S_END].neg_x ? -ext_x : ext_x;
      dy_nxt = side_r[S_END].neg_y ? -ext_y : ext_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flat_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 1; k <= S_END; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      if (cfg_valid) begin
        flat_r <= cfg_data;
      end
      if (en) begin
        vld_r[1] <= in_tvalid;
        for (int k = 2; k <= S_END; k++) begin
          vld_r[k] <= vld_r[k-1];
        end
        out_valid_r <= vld_r[S_END];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {dy_nxt, dx_nxt, grade_nxt};
      out_user_r <= {hd_nxt, side_r[S_END].status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== design/tsd_front.sv =====
// Front pipeline: edge vectors, cross product, magnitudes, squares and scaled radicand.
// Depends on tsd_pkg.
module tsd_front (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tsd_pkg::IN_W-1:0]   in_tdata,
  output tsd_pkg::side_t             side3,
  output logic [tsd_pkg::SQ_W-1:0]   mx2_6,
  output logic [tsd_pkg::H2_W-1:0]   h2_6,
  output logic [tsd_pkg::SQ_W-1:0]   my2_6,
  output logic [tsd_pkg::RAD_W-1:0]  rad_7
);
  import tsd_pkg::*;

  logic signed [COORD_W-1:0] c [NUM_COORD];
  logic signed [DIFF_W-1:0]  d_r [6];
  logic signed [PROD_W-1:0]  p_r [6];
  logic signed [NRM_W-1:0]   n   [3];
  logic [MAG_W-1:0]          m   [3];
  logic [2:0]                neg;
  logic [MAG_W-1:0]          mag_r [3];
  side_t                     side_r;
  side_t                     side_nxt;
  logic [2*HALF_W-1:0]       hh_r [2];
  logic [2*HALF_W-1:0]       hl_r [2];
  logic [2*HALF_W-1:0]       ll_r [2];
  logic [SQ_W-1:0]           sq_r [2];
  logic [SQ_W-1:0]           mx2_r;
  logic [SQ_W-1:0]           my2_r;
  logic [H2_W-1:0]           h2_r;
  logic [RAD_W-1:0]          rad_r;

  for (genvar i = 0; i < NUM_COORD; i++) begin : g_crd
    assign c[i] = in_tdata[i*COORD_W +: COORD_W];
  end

  assign n[0] = NRM_W'(p_r[0]) - NRM_W'(p_r[1]);
  assign n[1] = NRM_W'(p_r[2]) - NRM_W'(p_r[3]);
  assign n[2] = NRM_W'(p_r[4]) - NRM_W'(p_r[5]);

  for (genvar k = 0; k < 3; k++) begin : g_mag
    logic signed [NRM_W-1:0] neg_n;
    assign neg_n  = -n[k];
    assign neg[k] = n[k][NRM_W-1];
    assign m[k]   = neg[k] ? neg_n[MAG_W-1:0] : n[k][MAG_W-1:0];
  end

  always_comb begin
    side_nxt.neg_x = neg[0] ^ neg[2];
    side_nxt.neg_y = neg[1] ^ neg[2];
    side_nxt.mz    = m[2];
    if (m[0] == '0 && m[1] == '0 && m[2] == '0) begin
      side_nxt.status = ST_DEGEN;
    end else if (m[2] == '0) begin
      side_nxt.status = ST_VERT;
    end else begin
      side_nxt.status = ST_PLANAR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= DIFF_W'(c[3]) - DIFF_W'(c[0]);
      d_r[1] <= DIFF_W'(c[4]) - DIFF_W'(c[1]);
      d_r[2] <= DIFF_W'(c[5]) - DIFF_W'(c[2]);
      d_r[3] <= DIFF_W'(c[6]) - DIFF_W'(c[0]);
      d_r[4] <= DIFF_W'(c[7]) - DIFF_W'(c[1]);
      d_r[5] <= DIFF_W'(c[8]) - DIFF_W'(c[2]);
      p_r[0] <= d_r[1] * d_r[5];
      p_r[1] <= d_r[2] * d_r[4];
      p_r[2] <= d_r[2] * d_r[3];
      p_r[3] <= d_r[0] * d_r[5];
      p_r[4] <= d_r[0] * d_r[4];
      p_r[5] <= d_r[1] * d_r[3];
      for (int k = 0; k < 3; k++) begin
        mag_r[k] <= m[k];
      end
      side_r <= side_nxt;
      for (int k = 0; k < 2; k++) begin
        hh_r[k] <= mag_r[k][MAG_W-1:HALF_W] * mag_r[k][MAG_W-1:HALF_W];
        hl_r[k] <= mag_r[k][MAG_W-1:HALF_W] * mag_r[k][HALF_W-1:0];
        ll_r[k] <= mag_r[k][HALF_W-1:0] * mag_r[k][HALF_W-1:0];
        sq_r[k] <= (SQ_W'(hh_r[k]) << (2 * HALF_W)) + (SQ_W'(hl_r[k]) << (HALF_W + 1))
                   + SQ_W'(ll_r[k]);
      end
      mx2_r <= sq_r[0];
      my2_r <= sq_r[1];
      h2_r  <= H2_W'(sq_r[0]) + H2_W'(sq_r[1]);
      rad_r <= (RAD_W'(h2_r) << 29) + (RAD_W'(h2_r) << 26) + (RAD_W'(h2_r) << 25)
               + (RAD_W'(h2_r) << 24) + (RAD_W'(h2_r) << 20);
    end
  end

  assign side3 = side_r;
  assign mx2_6 = mx2_r;
  assign my2_6 = my2_r;
  assign h2_6  = h2_r;
  assign rad_7 = rad_r;

endmodule

// ===== design/tsd_sqrt_cell.sv =====
// One digit step of a restoring square root: brings down two radicand bits per cycle while en is high.
// Depends on tsd_pkg.
module tsd_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  tsd_pkg::sqrt_t d_in,
  output tsd_pkg::sqrt_t d_out
);
  import tsd_pkg::*;

  logic [REM_W-1:0] cur;
  logic [REM_W-1:0] trial;
  sqrt_t            cell_r;
  sqrt_t            cell_nxt;

  always_comb begin
    cur          = {d_in.rem[REM_W-3:0], d_in.rad[RAD_W-1:RAD_W-2]};
    trial        = {1'b0, d_in.root, 2'b01};
    cell_nxt.rad = {d_in.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      cell_nxt.rem  = cur - trial;
      cell_nxt.root = {d_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = cur;
      cell_nxt.root = {d_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

// ===== design/tsd_div_cell.sv =====
// One quotient bit of a restoring divider: shifts in one dividend bit per cycle while en is high.
// Depends on tsd_pkg.
module tsd_div_cell (
  input  logic          clk,
  input  logic          en,
  input  tsd_pkg::div_t d_in,
  output tsd_pkg::div_t d_out
);
  import tsd_pkg::*;

  logic [DREM_W-1:0] cur;
  logic [DREM_W-1:0] dvs_x;
  div_t              cell_r;
  div_t              cell_nxt;

  always_comb begin
    cur           = {d_in.rem[DREM_W-2:0], d_in.feed[FEED_W-1]};
    dvs_x         = {1'b0, d_in.dvs};
    cell_nxt.dvs  = d_in.dvs;
    cell_nxt.feed = {d_in.feed[FEED_W-2:0], 1'b0};
    if (cur >= dvs_x) begin
      cell_nxt.rem = cur - dvs_x;
      cell_nxt.quo = {d_in.quo[FEED_W-2:0], 1'b1};
    end else begin
      cell_nxt.rem = cur;
      cell_nxt.quo = {d_in.quo[FEED_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule

// ===== design/tsd_checker.sv =====
// Port-level checks for the triangle slope unit, bound to the top level.
// Depends on tsd_pkg and triangle_slope_and_downhill_unit.
module tsd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [tsd_pkg::IN_W-1:0]     in_tdata,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [tsd_pkg::OUT_W-1:0]    out_tdata,
  input logic [tsd_pkg::USER_W-1:0]   out_tuser,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [tsd_pkg::CFG_W-1:0]    cfg_data
);
  import tsd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transfer changed while stalled");

  a_dir_planar: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == ST_PLANAR)
    else $error("direction reported for a non-planar face");

  a_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tdata[OUT_W-1:GRADE_W] == '0)
    else $error("direction nonzero without direction flag");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ST_DEGEN |-> out_tdata[GRADE_W-1:0] == '0)
    else $error("degenerate face with nonzero grade");

  a_vert: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ST_VERT |-> out_tdata[GRADE_W-1:0] == GRADE_MAX)
    else $error("vertical face without saturated grade");

endmodule

bind triangle_slope_and_downhill_unit tsd_checker u_tsd_checker (.*);
